// ----- src/rcsl_pkg.sv -----
// Shared types, constants and the date comparison for the relay calendar lookup.
`timescale 1ns / 1ps
package rcsl_pkg;

  localparam int REC_BYTES = 5;
  localparam int CODE_BASE = 240;
  localparam int MINUTES_PER_HOUR = 60;
  localparam int PTR_W = 13;
  localparam int IDX_W = 12;
  localparam logic [IDX_W-1:0] ABSENT = '1;
  localparam logic [2:0] RD_LAST = 3'(REC_BYTES - 1);

  typedef enum logic [1:0] {
    OP_WRITE = 2'd0,
    OP_BUILD = 2'd1,
    OP_PROG  = 2'd2,
    OP_SIG   = 2'd3
  } op_t;

  typedef enum logic [1:0] {
    CMP_OTHER_RELAY = 2'd0,
    CMP_BEFORE      = 2'd1,
    CMP_SAME        = 2'd2,
    CMP_AFTER       = 2'd3
  } cmp_t;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_BUILD_START,
    ST_LOAD,
    ST_LAND,
    ST_HEAD,
    ST_SCAN1,
    ST_SCAN2,
    ST_REL_CHECK,
    ST_REL_FIRST,
    ST_REL_EVAL,
    ST_PIDX,
    ST_PCHECK,
    ST_SIG_EVAL,
    ST_FINISH
  } state_t;

  typedef struct packed {
    logic       capture;
    logic       wr_en;
    logic       clear;
    logic       ptr_zero;
    logic       ptr_add;
    logic       set_m0;
    logic       set_m1;
    logic       set_m2;
    logic       relay_upd;
    logic       prog_upd;
    logic       rel_start;
    logic       prog_start;
    logic       rd_en;
    logic       ahead;
    logic [2:0] rd_off;
    logic       shift;
    logic       hit_prev;
    logic       hit_rec;
    logic       finish;
  } ctl_t;

  typedef struct packed {
    logic rec_zero;
    logic next_in;
    logic walk_more;
    logic rel_span_ok;
    logic prog_span_ok;
    logic rel_hit;
    logic sig_hit;
  } sts_t;

  // Orders a yearly record against the queried date.
  function automatic cmp_t date_cmp(input logic [7:0] rc, input logic [7:0] ry,
                                    input logic [7:0] rm, input logic [7:0] rd,
                                    input logic [7:0] code, input logic [7:0] qy,
                                    input logic [3:0] qm, input logic [4:0] qd);
    cmp_t res;
    if (rc != code) begin
      res = CMP_OTHER_RELAY;
    end else if (ry != qy) begin
      res = (ry < qy) ? CMP_BEFORE : CMP_AFTER;
    end else if (rm != {4'b0, qm}) begin
      res = (rm < {4'b0, qm}) ? CMP_BEFORE : CMP_AFTER;
    end else if (rd != {3'b0, qd}) begin
      res = (rd < {3'b0, qd}) ? CMP_BEFORE : CMP_AFTER;
    end else begin
      res = CMP_SAME;
    end
    return res;
  endfunction

endpackage

// ----- src/relay_calendar_schedule_lookup.sv -----
// Top level of the relay calendar schedule lookup.
// Input channel (in_valid/in_ready) carries one command per transaction:
//   cmd 0 writes data_byte at addr into the record store, cmd 1 rebuilds the
//   marker, relay and program indexes, cmd 2 looks up the program in force for
//   relay_num on year/month/day, cmd 3 looks up the signal of program_num at
//   hour/minute on weekday. Every command returns one output transaction
//   (out_valid/out_ready) with found, value and layout_ok.
// One command is worked on at a time; in_ready is high only while idle.
// A write is taken in the accepting cycle and its result is posted from the finish step.
// Every record visited takes five reads through the single registered read
//   port of the store, then a step for the last byte to land and one to
//   evaluate it.
// The result sits in an output register; when the receiver stalls, the next
// command is accepted and runs, and holds in its last step until the waiting
// result is taken.
// Reset empties all index tables (absent) and clears out_valid; the store contents
// are undefined until written.
`timescale 1ns / 1ps
module relay_calendar_schedule_lookup #(
  parameter int RECORD_COUNT  = 256,
  parameter int RELAY_COUNT   = 6,
  parameter int PROGRAM_COUNT = 100
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic [1:0]  cmd,
  input  logic [10:0] addr,
  input  logic [7:0]  data_byte,
  input  logic [2:0]  relay_num,
  input  logic [7:0]  year,
  input  logic [3:0]  month,
  input  logic [4:0]  day,
  input  logic [6:0]  program_num,
  input  logic [4:0]  hour,
  input  logic [5:0]  minute,
  input  logic [2:0]  weekday,
  output logic        out_valid,
  input  logic        out_ready,
  output logic        found,
  output logic [7:0]  value,
  output logic        layout_ok
);

  rcsl_pkg::ctl_t ctl;
  rcsl_pkg::sts_t sts;

  rcsl_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .cmd       (cmd),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .sts       (sts),
    .ctl       (ctl)
  );

  rcsl_datapath #(
    .RECORD_COUNT  (RECORD_COUNT),
    .RELAY_COUNT   (RELAY_COUNT),
    .PROGRAM_COUNT (PROGRAM_COUNT)
  ) u_datapath (
    .clk         (clk),
    .rst         (rst),
    .ctl         (ctl),
    .sts         (sts),
    .addr        (addr),
    .data_byte   (data_byte),
    .relay_num   (relay_num),
    .year        (year),
    .month       (month),
    .day         (day),
    .program_num (program_num),
    .hour        (hour),
    .minute      (minute),
    .weekday     (weekday),
    .found       (found),
    .value       (value),
    .layout_ok   (layout_ok)
  );

endmodule

// ----- src/rcsl_ctrl.sv -----
// Sequencer for store writes, index builds and schedule walks.
`timescale 1ns / 1ps
module rcsl_ctrl (
  input  logic              clk,
  input  logic              rst,
  input  logic              in_valid,
  output logic              in_ready,
  input  logic [1:0]        cmd,
  output logic              out_valid,
  input  logic              out_ready,
  input  rcsl_pkg::sts_t    sts,
  output rcsl_pkg::ctl_t    ctl
);

  rcsl_pkg::state_t state, state_next, ret, ret_next;
  logic       ahead, ahead_next;
  logic [2:0] k, k_next;
  logic       accept;
  logic       out_valid_next;
  rcsl_pkg::op_t op;

  assign in_ready = (state == rcsl_pkg::ST_IDLE);
  assign accept   = in_valid && in_ready;
  assign op       = rcsl_pkg::op_t'(cmd);

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= rcsl_pkg::ST_IDLE;
      ret       <= rcsl_pkg::ST_IDLE;
      ahead     <= 1'b0;
      k         <= 3'd0;
      out_valid <= 1'b0;
    end else begin
      state     <= state_next;
      ret       <= ret_next;
      ahead     <= ahead_next;
      k         <= k_next;
      out_valid <= out_valid_next;
    end
  end

  assign out_valid_next = ctl.finish ? 1'b1 : (out_ready ? 1'b0 : out_valid);

  always_comb begin
    state_next = state;
    ret_next   = ret;
    ahead_next = ahead;
    k_next     = k;
    unique case (state)
      rcsl_pkg::ST_IDLE: begin
        if (accept) begin
          unique case (op)
            rcsl_pkg::OP_WRITE: state_next = rcsl_pkg::ST_FINISH;
            rcsl_pkg::OP_BUILD: state_next = rcsl_pkg::ST_BUILD_START;
            rcsl_pkg::OP_PROG:  state_next = rcsl_pkg::ST_REL_CHECK;
            rcsl_pkg::OP_SIG:   state_next = rcsl_pkg::ST_PIDX;
          endcase
        end
      end
      rcsl_pkg::ST_BUILD_START: begin
        state_next = rcsl_pkg::ST_LOAD;
        ret_next   = rcsl_pkg::ST_HEAD;
        ahead_next = 1'b0;
        k_next     = 3'd0;
      end
      rcsl_pkg::ST_LOAD: begin
        k_next = k + 3'd1;
        if (k == rcsl_pkg::RD_LAST) begin
          state_next = rcsl_pkg::ST_LAND;
        end
      end
      rcsl_pkg::ST_LAND: begin
        state_next = ret;
      end
      rcsl_pkg::ST_HEAD: begin
        if (!sts.rec_zero) begin
          state_next = rcsl_pkg::ST_FINISH;
        end else begin
          state_next = rcsl_pkg::ST_LOAD;
          ret_next   = rcsl_pkg::ST_SCAN1;
          k_next     = 3'd0;
        end
      end
      rcsl_pkg::ST_SCAN1: begin
        if (!sts.next_in) begin
          state_next = rcsl_pkg::ST_FINISH;
        end else begin
          state_next = rcsl_pkg::ST_LOAD;
          ret_next   = sts.rec_zero ? rcsl_pkg::ST_SCAN2 : rcsl_pkg::ST_SCAN1;
          k_next     = 3'd0;
        end
      end
      rcsl_pkg::ST_SCAN2: begin
        if (sts.rec_zero || !sts.next_in) begin
          state_next = rcsl_pkg::ST_FINISH;
        end else begin
          state_next = rcsl_pkg::ST_LOAD;
          ret_next   = rcsl_pkg::ST_SCAN2;
          k_next     = 3'd0;
        end
      end
      rcsl_pkg::ST_REL_CHECK: begin
        if (!sts.rel_span_ok) begin
          state_next = rcsl_pkg::ST_FINISH;
        end else begin
          state_next = rcsl_pkg::ST_LOAD;
          ret_next   = rcsl_pkg::ST_REL_FIRST;
          ahead_next = 1'b0;
          k_next     = 3'd0;
        end
      end
      rcsl_pkg::ST_REL_FIRST: begin
        state_next = rcsl_pkg::ST_LOAD;
        ret_next   = rcsl_pkg::ST_REL_EVAL;
        ahead_next = 1'b1;
        k_next     = 3'd0;
      end
      rcsl_pkg::ST_REL_EVAL: begin
        if (sts.rel_hit || !sts.walk_more) begin
          state_next = rcsl_pkg::ST_FINISH;
        end else begin
          state_next = rcsl_pkg::ST_LOAD;
          ret_next   = rcsl_pkg::ST_REL_EVAL;
          ahead_next = 1'b1;
          k_next     = 3'd0;
        end
      end
      rcsl_pkg::ST_PIDX: begin
        state_next = rcsl_pkg::ST_PCHECK;
      end
      rcsl_pkg::ST_PCHECK: begin
        if (!sts.prog_span_ok) begin
          state_next = rcsl_pkg::ST_FINISH;
        end else begin
          state_next = rcsl_pkg::ST_LOAD;
          ret_next   = rcsl_pkg::ST_SIG_EVAL;
          ahead_next = 1'b0;
          k_next     = 3'd0;
        end
      end
      rcsl_pkg::ST_SIG_EVAL: begin
        if (sts.sig_hit || !sts.walk_more) begin
          state_next = rcsl_pkg::ST_FINISH;
        end else begin
          state_next = rcsl_pkg::ST_LOAD;
          ret_next   = rcsl_pkg::ST_SIG_EVAL;
          ahead_next = 1'b0;
          k_next     = 3'd0;
        end
      end
      rcsl_pkg::ST_FINISH: begin
        if (!out_valid || out_ready) begin
          state_next = rcsl_pkg::ST_IDLE;
        end
      end
      default: state_next = rcsl_pkg::ST_IDLE;
    endcase
  end

  always_comb begin
    ctl = '0;
    unique case (state)
      rcsl_pkg::ST_IDLE: begin
        ctl.capture = accept;
        ctl.wr_en   = accept && (op == rcsl_pkg::OP_WRITE);
      end
      rcsl_pkg::ST_BUILD_START: begin
        ctl.clear    = 1'b1;
        ctl.ptr_zero = 1'b1;
      end
      rcsl_pkg::ST_LOAD: begin
        ctl.rd_en  = 1'b1;
        ctl.rd_off = k;
        ctl.ahead  = ahead;
      end
      rcsl_pkg::ST_HEAD: begin
        ctl.set_m0  = sts.rec_zero;
        ctl.ptr_add = sts.rec_zero;
      end
      rcsl_pkg::ST_SCAN1: begin
        ctl.set_m1    = sts.rec_zero;
        ctl.relay_upd = !sts.rec_zero;
        ctl.ptr_add   = 1'b1;
      end
      rcsl_pkg::ST_SCAN2: begin
        ctl.set_m2   = sts.rec_zero;
        ctl.prog_upd = !sts.rec_zero;
        ctl.ptr_add  = 1'b1;
      end
      rcsl_pkg::ST_REL_CHECK: begin
        ctl.rel_start = 1'b1;
      end
      rcsl_pkg::ST_REL_FIRST: begin
        ctl.shift = 1'b1;
      end
      rcsl_pkg::ST_REL_EVAL: begin
        ctl.hit_prev = sts.rel_hit;
        ctl.ptr_add  = !sts.rel_hit;
        ctl.shift    = !sts.rel_hit;
      end
      rcsl_pkg::ST_PCHECK: begin
        ctl.prog_start = 1'b1;
      end
      rcsl_pkg::ST_SIG_EVAL: begin
        ctl.hit_rec = sts.sig_hit;
        ctl.ptr_add = !sts.sig_hit;
      end
      rcsl_pkg::ST_FINISH: begin
        ctl.finish = !out_valid || out_ready;
      end
      default: ctl = '0;
    endcase
  end

  a_accept_leaves_idle: assert property (@(posedge clk) disable iff (rst)
    accept |=> state != rcsl_pkg::ST_IDLE)
    else $error("accepted transaction did not start work");

  a_load_ends: assert property (@(posedge clk) disable iff (rst)
    (state == rcsl_pkg::ST_LOAD && k == rcsl_pkg::RD_LAST) |=> state == rcsl_pkg::ST_LAND)
    else $error("record load overran five bytes");

  a_k_range: assert property (@(posedge clk) disable iff (rst)
    state == rcsl_pkg::ST_LOAD |-> k <= rcsl_pkg::RD_LAST)
    else $error("byte counter out of range");

  a_finish_shows: assert property (@(posedge clk) disable iff (rst)
    ctl.finish |=> out_valid)
    else $error("finished result not presented");

endmodule

// ----- src/rcsl_datapath.sv -----
// Record store, index tables, record buffers and match logic.
`timescale 1ns / 1ps
module rcsl_datapath #(
  parameter int RECORD_COUNT  = 256,
  parameter int RELAY_COUNT   = 6,
  parameter int PROGRAM_COUNT = 100
) (
  input  logic              clk,
  input  logic              rst,
  input  rcsl_pkg::ctl_t    ctl,
  output rcsl_pkg::sts_t    sts,
  input  logic [10:0]       addr,
  input  logic [7:0]        data_byte,
  input  logic [2:0]        relay_num,
  input  logic [7:0]        year,
  input  logic [3:0]        month,
  input  logic [4:0]        day,
  input  logic [6:0]        program_num,
  input  logic [4:0]        hour,
  input  logic [5:0]        minute,
  input  logic [2:0]        weekday,
  output logic              found,
  output logic [7:0]        value,
  output logic              layout_ok
);

  localparam int STORE_BYTES = RECORD_COUNT * rcsl_pkg::REC_BYTES;
  localparam int AW = $clog2(STORE_BYTES);
  localparam int RW = $clog2(RELAY_COUNT + 1);
  localparam int PW = $clog2(PROGRAM_COUNT + 1);
  localparam int PTW = rcsl_pkg::PTR_W;
  localparam int IW = rcsl_pkg::IDX_W;

  logic [7:0] store_mem [STORE_BYTES];
  logic [IW-1:0] pfirst_mem [PROGRAM_COUNT];
  logic [IW-1:0] plast_mem [PROGRAM_COUNT];

  logic [2:0] relay_r;
  logic [7:0] year_r;
  logic [3:0] month_r;
  logic [4:0] day_r;
  logic [6:0] prog_r;
  logic [4:0] hour_r;
  logic [5:0] minute_r;
  logic [2:0] wday_r;

  logic [PTW-1:0] ptr, rd_addr, ptr_plus;
  logic [IW-1:0]  span_last;
  logic [IW-1:0]  m0, m1, m2;
  logic [IW-1:0]  rf [RELAY_COUNT+1];
  logic [IW-1:0]  rl [RELAY_COUNT+1];
  logic [PROGRAM_COUNT-1:0] pvalid;
  logic [IW-1:0]  pf_q, pl_q;
  logic           pv_q;
  logic [7:0]     rec  [rcsl_pkg::REC_BYTES];
  logic [7:0]     prev [rcsl_pkg::REC_BYTES];
  logic [7:0]     mem_q;
  logic           pend_q, in_q;
  logic [2:0]     slot_q;
  logic           hit_r;
  logic [7:0]     val_r;

  logic           rd_in, wr_in;
  logic [RW-1:0]  upd_ri, q_ri;
  logic [PW-1:0]  upd_pi, q_pi;
  logic           relay_code_ok, prog_code_ok, rel_in, prog_in;
  logic [IW-1:0]  rel_f, rel_l;
  logic [7:0]     code;
  rcsl_pkg::cmp_t c1, c2;
  logic [13:0]    rec_time;
  logic [10:0]    now;
  logic [7:0]     mask;
  logic           layout;

  assign ptr_plus = ptr + PTW'(rcsl_pkg::REC_BYTES);
  assign rd_addr  = ptr + (ctl.ahead ? PTW'(rcsl_pkg::REC_BYTES) : '0) + PTW'(ctl.rd_off);
  assign rd_in    = rd_addr < PTW'(STORE_BYTES);
  assign wr_in    = PTW'(addr) < PTW'(STORE_BYTES);

  always_ff @(posedge clk) begin
    if (ctl.capture) begin
      relay_r  <= relay_num;
      year_r   <= year;
      month_r  <= month;
      day_r    <= day;
      prog_r   <= program_num;
      hour_r   <= hour;
      minute_r <= minute;
      wday_r   <= weekday;
    end
  end

  // Byte store: one write port for loading, one registered read port for the walks.
  always_ff @(posedge clk) begin
    if (ctl.wr_en && wr_in) begin
      store_mem[AW'(addr)] <= data_byte;
    end
    mem_q <= store_mem[rd_addr[AW-1:0]];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      pend_q <= 1'b0;
    end else begin
      pend_q <= ctl.rd_en;
    end
    in_q   <= rd_in;
    slot_q <= ctl.rd_off;
  end

  // Bytes past the end of the store read as zero.
  always_ff @(posedge clk) begin
    if (pend_q) begin
      rec[slot_q] <= in_q ? mem_q : 8'd0;
    end
    if (ctl.shift) begin
      prev <= rec;
    end
  end

  assign relay_code_ok = (rec[0] > 8'(rcsl_pkg::CODE_BASE)) &&
                         (rec[0] <= 8'(rcsl_pkg::CODE_BASE + RELAY_COUNT));
  assign upd_ri        = RW'(rec[0] - 8'(rcsl_pkg::CODE_BASE));
  assign prog_code_ok  = rec[0] < 8'(PROGRAM_COUNT);
  assign upd_pi        = PW'(rec[0]);

  always_ff @(posedge clk) begin
    if (rst || ctl.clear) begin
      m0 <= rcsl_pkg::ABSENT;
      m1 <= rcsl_pkg::ABSENT;
      m2 <= rcsl_pkg::ABSENT;
      for (int i = 0; i <= RELAY_COUNT; i++) begin
        rf[i] <= rcsl_pkg::ABSENT;
        rl[i] <= rcsl_pkg::ABSENT;
      end
      pvalid <= '0;
    end else begin
      if (ctl.set_m0) m0 <= '0;
      if (ctl.set_m1) m1 <= ptr[IW-1:0];
      if (ctl.set_m2) m2 <= ptr[IW-1:0];
      if (ctl.relay_upd && relay_code_ok) begin
        if (rf[upd_ri] == rcsl_pkg::ABSENT) rf[upd_ri] <= ptr[IW-1:0];
        rl[upd_ri] <= ptr[IW-1:0];
      end
      if (ctl.prog_upd && prog_code_ok) begin
        pvalid[upd_pi] <= 1'b1;
      end
    end
  end

  assign prog_in = {1'b0, prog_r} < 8'(PROGRAM_COUNT);
  assign q_pi    = PW'(prog_r);

  // Program span tables; an entry without its valid bit reads as absent.
  always_ff @(posedge clk) begin
    if (ctl.prog_upd && prog_code_ok) begin
      if (!pvalid[upd_pi]) pfirst_mem[upd_pi] <= ptr[IW-1:0];
      plast_mem[upd_pi] <= ptr[IW-1:0];
    end
    pf_q <= pfirst_mem[q_pi];
    pl_q <= plast_mem[q_pi];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      pv_q <= 1'b0;
    end else begin
      pv_q <= prog_in && pvalid[q_pi];
    end
  end

  assign rel_in = (relay_r != 3'd0) && ({1'b0, relay_r} <= 4'(RELAY_COUNT));
  assign q_ri   = RW'(relay_r);
  assign rel_f  = rf[q_ri];
  assign rel_l  = rl[q_ri];

  always_ff @(posedge clk) begin
    priority if (ctl.ptr_zero) begin
      ptr <= '0;
    end else if (ctl.rel_start) begin
      ptr       <= {1'b0, rel_f};
      span_last <= rel_l;
    end else if (ctl.prog_start) begin
      ptr       <= {1'b0, pf_q};
      span_last <= pl_q;
    end else if (ctl.ptr_add) begin
      ptr <= ptr_plus;
    end
  end

  assign code = 8'(relay_r) + 8'(rcsl_pkg::CODE_BASE);
  assign c1 = rcsl_pkg::date_cmp(prev[0], prev[1], prev[2], prev[3], code,
                                 year_r, month_r, day_r);
  assign c2 = rcsl_pkg::date_cmp(rec[0], rec[1], rec[2], rec[3], code,
                                 year_r, month_r, day_r);

  assign rec_time = 14'(rec[1]) * 14'(rcsl_pkg::MINUTES_PER_HOUR) + 14'(rec[2]);
  assign now      = 11'(hour_r) * 11'(rcsl_pkg::MINUTES_PER_HOUR) + 11'(minute_r);
  assign mask     = 8'h80 >> wday_r;

  assign sts.rec_zero     = (rec[0] == 8'd0) && (rec[1] == 8'd0) && (rec[2] == 8'd0) &&
                            (rec[3] == 8'd0) && (rec[4] == 8'd0);
  assign sts.next_in      = ptr_plus < PTW'(STORE_BYTES);
  assign sts.walk_more    = ptr_plus <= {1'b0, span_last};
  assign sts.rel_span_ok  = rel_in && (rel_f != rcsl_pkg::ABSENT) &&
                            (rel_l != rcsl_pkg::ABSENT) && (rel_f <= rel_l);
  assign sts.prog_span_ok = pv_q && (pf_q <= pl_q);
  assign sts.rel_hit      = (c1 != rcsl_pkg::CMP_AFTER) &&
                            ((c2 == rcsl_pkg::CMP_OTHER_RELAY) || (c2 == rcsl_pkg::CMP_AFTER));
  assign sts.sig_hit      = (rec_time == 14'(now)) && ((rec[3] & mask) != 8'd0);

  assign layout = (m0 == '0) && (m1 != rcsl_pkg::ABSENT) && (m2 != rcsl_pkg::ABSENT) &&
                  (m0 < m1) && (m1 < m2) &&
                  ({1'b0, m2} < PTW'(STORE_BYTES + rcsl_pkg::REC_BYTES));

  always_ff @(posedge clk) begin
    priority if (ctl.capture) begin
      hit_r <= 1'b0;
      val_r <= 8'd0;
    end else if (ctl.hit_prev) begin
      hit_r <= 1'b1;
      val_r <= prev[4];
    end else if (ctl.hit_rec) begin
      hit_r <= 1'b1;
      val_r <= rec[4];
    end
    if (ctl.finish) begin
      found     <= hit_r;
      value     <= val_r;
      layout_ok <= layout;
    end
  end

endmodule

// ----- tb/sv/testbench.sv -----
// Self-checking testbench for the relay calendar schedule lookup.
`timescale 1ns / 1ps
module testbench;

  localparam int STORE_BYTES = 1280;
  localparam int RELAYS = 6;
  localparam int PROGRAMS = 100;
  localparam int WATCHDOG_LIMIT = 20000;

  typedef struct packed {
    rcsl_pkg::op_t op;
    logic [10:0] addr;
    logic [7:0] data;
    logic [2:0] relay;
    logic [7:0] year;
    logic [3:0] month;
    logic [4:0] day;
    logic [6:0] prog;
    logic [4:0] hour;
    logic [5:0] minute;
    logic [2:0] wday;
    logic       drain;
  } command_t;

  typedef struct packed {
    logic       found;
    logic [7:0] value;
    logic       layout;
  } lookup_t;

  logic clk = 0;
  logic rst = 1;
  logic in_valid = 0;
  logic out_ready = 0;
  logic in_ready, out_valid, found, layout_ok;
  logic [7:0] value;
  command_t cur = '0;

  command_t pending[$];
  lookup_t due_results[$];
  int errors = 0;
  int send_gap = 0;
  int recv_stall = 0;
  bit quiet = 0;
  bit in_fire = 0;
  int idle_cycles = 0;

  // Predictor state.
  logic [7:0] sched_mem[STORE_BYTES];
  logic [rcsl_pkg::IDX_W-1:0] mark[3];
  logic [rcsl_pkg::IDX_W-1:0] rel_first[RELAYS+1], rel_last[RELAYS+1];
  logic [rcsl_pkg::IDX_W-1:0] prog_first[PROGRAMS], prog_last[PROGRAMS];

  // Records of the current schedule, kept so queries can aim at them.
  int yr_rel[$], yr_y[$], yr_m[$], yr_d[$];
  int wk_p[$], wk_h[$], wk_mi[$];

  relay_calendar_schedule_lookup dut (
    .clk(clk), .rst(rst), .in_valid(in_valid), .in_ready(in_ready),
    .cmd(cur.op), .addr(cur.addr), .data_byte(cur.data), .relay_num(cur.relay),
    .year(cur.year), .month(cur.month), .day(cur.day), .program_num(cur.prog),
    .hour(cur.hour), .minute(cur.minute), .weekday(cur.wday),
    .out_valid(out_valid), .out_ready(out_ready), .found(found), .value(value),
    .layout_ok(layout_ok)
  );

  initial begin
    forever #5 clk = ~clk;
  end

  function automatic int byte_at(int a);
    return (a < STORE_BYTES) ? int'(sched_mem[a]) : 0;
  endfunction

  function automatic bit is_blank(int p);
    for (int k = 0; k < rcsl_pkg::REC_BYTES; k++) begin
      if (byte_at(p + k) != 0) return 0;
    end
    return 1;
  endfunction

  function automatic rcsl_pkg::cmp_t order_date(int p, int code, int y, int m, int d);
    if (byte_at(p) != code) return rcsl_pkg::CMP_OTHER_RELAY;
    if (byte_at(p + 1) != y)
      return (byte_at(p + 1) < y) ? rcsl_pkg::CMP_BEFORE : rcsl_pkg::CMP_AFTER;
    if (byte_at(p + 2) != m)
      return (byte_at(p + 2) < m) ? rcsl_pkg::CMP_BEFORE : rcsl_pkg::CMP_AFTER;
    if (byte_at(p + 3) != d)
      return (byte_at(p + 3) < d) ? rcsl_pkg::CMP_BEFORE : rcsl_pkg::CMP_AFTER;
    return rcsl_pkg::CMP_SAME;
  endfunction

  function automatic void rebuild_indexes();
    int pos;
    int c;
    bit stop;
    foreach (mark[k]) mark[k] = rcsl_pkg::ABSENT;
    foreach (rel_first[k]) begin
      rel_first[k] = rcsl_pkg::ABSENT;
      rel_last[k] = rcsl_pkg::ABSENT;
    end
    foreach (prog_first[k]) begin
      prog_first[k] = rcsl_pkg::ABSENT;
      prog_last[k] = rcsl_pkg::ABSENT;
    end
    if (!is_blank(0)) return;
    mark[0] = '0;
    pos = rcsl_pkg::REC_BYTES;
    stop = 0;
    do begin
      if (is_blank(pos)) begin
        mark[1] = rcsl_pkg::IDX_W'(pos);
        stop = 1;
      end else begin
        c = byte_at(pos);
        if (c > rcsl_pkg::CODE_BASE && c <= rcsl_pkg::CODE_BASE + RELAYS) begin
          c -= rcsl_pkg::CODE_BASE;
          if (rel_first[c] == rcsl_pkg::ABSENT) rel_first[c] = rcsl_pkg::IDX_W'(pos);
          rel_last[c] = rcsl_pkg::IDX_W'(pos);
        end
      end
      pos += rcsl_pkg::REC_BYTES;
    end while (pos < STORE_BYTES && !stop);
    if (pos < STORE_BYTES) begin
      stop = 0;
      do begin
        if (is_blank(pos)) begin
          mark[2] = rcsl_pkg::IDX_W'(pos);
          stop = 1;
        end else begin
          c = byte_at(pos);
          if (c < PROGRAMS) begin
            if (prog_first[c] == rcsl_pkg::ABSENT) prog_first[c] = rcsl_pkg::IDX_W'(pos);
            prog_last[c] = rcsl_pkg::IDX_W'(pos);
          end
        end
        pos += rcsl_pkg::REC_BYTES;
      end while (pos < STORE_BYTES && !stop);
    end
  endfunction

  function automatic bit layout_good();
    if (mark[0] != 0 || mark[1] == rcsl_pkg::ABSENT || mark[2] == rcsl_pkg::ABSENT) return 0;
    if (mark[0] >= mark[1] || mark[1] >= mark[2]) return 0;
    return int'(mark[2]) < STORE_BYTES + rcsl_pkg::REC_BYTES;
  endfunction

  function automatic lookup_t run_command(command_t c);
    lookup_t r;
    int f, l, i, code, now_min, mask;
    rcsl_pkg::cmp_t here, next_rec;
    r = '0;
    case (c.op)
      rcsl_pkg::OP_WRITE: begin
        if (c.addr < STORE_BYTES) sched_mem[c.addr] = c.data;
      end
      rcsl_pkg::OP_BUILD: rebuild_indexes();
      rcsl_pkg::OP_PROG: begin
        if (c.relay >= 1 && c.relay <= RELAYS) begin
          f = int'(rel_first[c.relay]);
          l = int'(rel_last[c.relay]);
          if (f != rcsl_pkg::ABSENT && l != rcsl_pkg::ABSENT && f <= l) begin
            code = int'(c.relay) + rcsl_pkg::CODE_BASE;
            i = f;
            do begin
              here = order_date(i, code, c.year, c.month, c.day);
              next_rec = order_date(i + rcsl_pkg::REC_BYTES, code, c.year, c.month, c.day);
              if (here != rcsl_pkg::CMP_AFTER && (next_rec == rcsl_pkg::CMP_OTHER_RELAY ||
                  next_rec == rcsl_pkg::CMP_AFTER)) begin
                r.found = 1'b1;
                r.value = 8'(byte_at(i + 4));
                break;
              end
              i += rcsl_pkg::REC_BYTES;
            end while (i <= l);
          end
        end
      end
      rcsl_pkg::OP_SIG: begin
        if (c.prog < PROGRAMS) begin
          f = int'(prog_first[c.prog]);
          l = int'(prog_last[c.prog]);
          if (f != rcsl_pkg::ABSENT && l != rcsl_pkg::ABSENT && f <= l) begin
            now_min = int'(c.hour) * rcsl_pkg::MINUTES_PER_HOUR + int'(c.minute);
            mask = int'(8'h80) >> c.wday;
            i = f;
            do begin
              if (byte_at(i + 1) * rcsl_pkg::MINUTES_PER_HOUR + byte_at(i + 2) == now_min &&
                  (byte_at(i + 3) & mask) != 0) begin
                r.found = 1'b1;
                r.value = 8'(byte_at(i + 4));
                break;
              end
              i += rcsl_pkg::REC_BYTES;
            end while (i <= l);
          end
        end
      end
    endcase
    r.layout = layout_good();
    return r;
  endfunction

  task automatic report(string what, int got, int want);
    $display("mismatch at %0t: %s got %0d expected %0d", $realtime, what, got, want);
    errors++;
  endtask

  // Unused fields carry random values so every input bit moves.
  function automatic command_t random_command(rcsl_pkg::op_t op);
    command_t c;
    c.op = op;
    c.addr = 11'($urandom);
    c.data = 8'($urandom);
    c.relay = 3'($urandom);
    c.year = 8'($urandom);
    c.month = 4'($urandom_range(0, 12));
    c.day = 5'($urandom);
    c.prog = 7'($urandom_range(0, 127));
    c.hour = 5'($urandom_range(0, 23));
    c.minute = 6'($urandom_range(0, 59));
    c.wday = 3'($urandom);
    c.drain = 1'b0;
    return c;
  endfunction

  task automatic put_write(int a, int d);
    command_t c;
    c = random_command(rcsl_pkg::OP_WRITE);
    c.addr = 11'(a);
    c.data = 8'(d);
    pending.push_back(c);
  endtask

  task automatic put_record(int rec, int b0, int b1, int b2, int b3, int b4);
    put_write(rec * 5, b0);
    put_write(rec * 5 + 1, b1);
    put_write(rec * 5 + 2, b2);
    put_write(rec * 5 + 3, b3);
    put_write(rec * 5 + 4, b4);
  endtask

  task automatic put_build(bit drain);
    command_t c;
    c = random_command(rcsl_pkg::OP_BUILD);
    c.drain = drain;
    pending.push_back(c);
  endtask

  task automatic put_prog(int r, int y, int m, int d);
    command_t c;
    c = random_command(rcsl_pkg::OP_PROG);
    c.relay = 3'(r);
    c.year = 8'(y);
    c.month = 4'(m);
    c.day = 5'(d);
    pending.push_back(c);
  endtask

  task automatic put_sig(int p, int h, int mi, int w);
    command_t c;
    c = random_command(rcsl_pkg::OP_SIG);
    c.prog = 7'(p);
    c.hour = 5'(h);
    c.minute = 6'(mi);
    c.wday = 3'(w);
    pending.push_back(c);
  endtask

  // One schedule: leading marker, yearly part, marker, weekly part, marker.
  // Now and then a marker is spoiled so the scans run on into old records.
  task automatic put_schedule();
    int n_year, n_week, rec, flaw, k, y;
    n_year = $urandom_range(1, 8);
    n_week = $urandom_range(1, 8);
    flaw = $urandom_range(0, 11);
    yr_rel.delete(); yr_y.delete(); yr_m.delete(); yr_d.delete();
    wk_p.delete(); wk_h.delete(); wk_mi.delete();
    put_record(0, 0, 0, 0, 0, (flaw == 0) ? $urandom_range(1, 255) : 0);
    rec = 1;
    y = $urandom_range(20, 22);
    for (k = 0; k < n_year; k++) begin
      yr_rel.push_back(($urandom_range(0, 7) == 0) ? $urandom_range(0, 7) : $urandom_range(1, 3));
      yr_y.push_back(($urandom_range(0, 9) == 0) ? (($urandom_range(0, 1)) ? 255 : 0) : y + k / 3);
      yr_m.push_back($urandom_range(0, 12));
      yr_d.push_back($urandom_range(0, 31));
      put_record(rec, ($urandom_range(0, 9) == 0) ? $urandom : rcsl_pkg::CODE_BASE + yr_rel[k],
                 yr_y[k], yr_m[k], yr_d[k], $urandom);
      rec++;
    end
    put_record(rec, 0, 0, 0, 0, (flaw == 1) ? $urandom_range(1, 255) : 0);
    rec++;
    for (k = 0; k < n_week; k++) begin
      wk_p.push_back(($urandom_range(0, 9) == 0) ? $urandom_range(100, 255) : $urandom_range(0, 4));
      wk_h.push_back($urandom_range(0, 23));
      wk_mi.push_back(($urandom_range(0, 1)) ? $urandom_range(0, 3) * 15 : $urandom_range(0, 59));
      put_record(rec, wk_p[k], wk_h[k], wk_mi[k], $urandom, $urandom);
      rec++;
    end
    put_record(rec, 0, 0, 0, 0, (flaw == 2) ? $urandom_range(1, 255) : 0);
    put_build($urandom_range(0, 3) == 0);
  endtask

  task automatic put_queries();
    int n, k, j;
    n = $urandom_range(6, 18);
    for (k = 0; k < n; k++) begin
      j = $urandom_range(0, 7);
      if (j < 3) begin
        j = $urandom_range(0, yr_rel.size() - 1);
        put_prog(yr_rel[j], yr_y[j], yr_m[j], yr_d[j] + $urandom_range(0, 2) - 1);
      end else if (j < 6) begin
        j = $urandom_range(0, wk_p.size() - 1);
        put_sig(wk_p[j], wk_h[j], wk_mi[j], $urandom);
      end else if (j == 6) begin
        put_prog($urandom, $urandom_range(19, 23), $urandom_range(0, 12), $urandom);
      end else begin
        put_sig($urandom_range(0, 127), $urandom_range(0, 23), $urandom_range(0, 59), $urandom);
      end
    end
  endtask

  // Driver: new transactions go out at the falling edge.
  always @(negedge clk) begin
    if (!rst) begin
      if (pending.size() < 150) quiet = 1;
      if (!in_valid || in_fire) begin
        if (send_gap > 0) begin
          send_gap--;
          in_valid <= 0;
        end else if (pending.size() > 0 && !(pending[0].drain && due_results.size() > 0)) begin
          cur <= pending.pop_front();
          in_valid <= 1;
          if (!quiet && $urandom_range(0, 9) == 0) send_gap = $urandom_range(1, 13);
        end else begin
          in_valid <= 0;
        end
      end
      if (recv_stall > 0) begin
        recv_stall--;
        out_ready <= 0;
      end else begin
        out_ready <= 1;
        if (!quiet && $urandom_range(0, 9) == 0) recv_stall = $urandom_range(1, 13);
      end
    end
  end

  // Monitor: predict on accepted commands, check accepted results.
  always @(posedge clk) begin
    lookup_t want;
    in_fire = in_valid && in_ready;
    if (in_fire) due_results.push_back(run_command(cur));
    if (out_valid && out_ready) begin
      if (due_results.size() == 0) begin
        report("unexpected result found", found, 0);
      end else begin
        want = due_results.pop_front();
        if (found !== want.found) report("found", found, want.found);
        if (value !== want.value) report("value", value, want.value);
        if (layout_ok !== want.layout) report("layout_ok", layout_ok, want.layout);
      end
    end
    if (in_fire || (out_valid && out_ready)) idle_cycles = 0;
    else idle_cycles++;
    if (idle_cycles >= WATCHDOG_LIMIT) begin
      $display("[FAIL] regression broken");
      $finish;
    end
  end

  initial begin
    int k;
    int sent;
    foreach (sched_mem[k]) sched_mem[k] = 0;
    foreach (mark[k]) mark[k] = rcsl_pkg::ABSENT;
    foreach (rel_first[k]) begin
      rel_first[k] = rcsl_pkg::ABSENT;
      rel_last[k] = rcsl_pkg::ABSENT;
    end
    foreach (prog_first[k]) begin
      prog_first[k] = rcsl_pkg::ABSENT;
      prog_last[k] = rcsl_pkg::ABSENT;
    end

    // Every store byte is written once before anything can read it.
    for (k = 0; k < STORE_BYTES; k++) put_write(k, 0);
    put_write(STORE_BYTES, 8'hFF);
    put_write(2047, 8'hA5);
    put_prog(1, 0, 0, 0);
    put_sig(0, 0, 0, 0);
    put_build(0);
    put_prog(0, 255, 12, 31);
    put_prog(7, 255, 12, 31);
    put_prog(6, 0, 0, 0);
    put_sig(99, 23, 59, 7);
    put_sig(100, 0, 0, 0);
    put_sig(127, 23, 59, 7);

    // One relay spanning the whole store: the last walk reads past the end.
    for (k = 1; k < 256; k++) put_write(k * 5, rcsl_pkg::CODE_BASE + 1);
    put_build(1);
    put_prog(1, 0, 0, 0);
    put_prog(1, 255, 12, 31);
    put_prog(2, 0, 0, 0);

    sent = pending.size();
    while (sent < 1850) begin
      k = pending.size();
      put_schedule();
      put_queries();
      if ($urandom_range(0, 3) == 0) put_write($urandom_range(0, 2047), $urandom);
      if ($urandom_range(0, 5) == 0) put_build(0);
      sent += pending.size() - k;
    end

    repeat (8) @(negedge clk);
    rst = 0;

    while (pending.size() > 0 || in_valid || due_results.size() > 0) @(posedge clk);
    repeat (50) @(posedge clk);
    if (errors == 0 && due_results.size() == 0) begin
      $display("[ OK ] regression clean");
    end else begin
      $display("[FAIL] regression broken");
    end
    $finish;
  end

endmodule
